>>> sv/tevq_pkg.sv
package tevq_pkg;

  typedef enum logic [2:0] {
    OP_POST  = 3'd0,
    OP_CANCEL = 3'd1,
    OP_REG   = 3'd2,
    OP_UNREG = 3'd3,
    OP_PROC  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    KIND_POST,
    KIND_CANCEL,
    KIND_REG,
    KIND_UNREG,
    KIND_PROC,
    KIND_NOP
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_FULL     = 4'd1,
    ST_NOTFOUND = 4'd2,
    ST_NOSLOT   = 4'd3,
    ST_BADID    = 4'd4,
    ST_FIRE     = 4'd5,
    ST_DROPPED  = 4'd6,
    ST_DEFERRED = 4'd7,
    ST_DONE     = 4'd8,
    ST_IDLE     = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CRD,
    S_CCHK,
    S_PRD,
    S_PCHK,
    S_FIRE,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  evt_type;
    logic [31:0] creator;
    logic [31:0] target;
    logic [7:0]  priority_req;
    logic [31:0] fire_time;
    logic [31:0] payload;
    logic [31:0] cancel_id;
    logic [15:0] drop_listener;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  etype;
    logic [31:0] creator;
    logic [31:0] target;
    logic [7:0]  prio;
    logic [31:0] fire_time;
    logic [31:0] payload;
    logic        done;
  } entry_t;

endpackage

>>> sv/tevq_if.sv
interface tevq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  evt_type;
  logic [31:0] creator;
  logic [31:0] target;
  logic [7:0]  priority_req;
  logic [31:0] fire_time;
  logic [31:0] payload;
  logic [31:0] cancel_id;
  logic [15:0] drop_listener;
  logic [31:0] now;
  modport source (output valid, operation, evt_type, creator, target, priority_req,
                  fire_time, payload, cancel_id, drop_listener, now, input ready);
  modport sink (input valid, operation, evt_type, creator, target, priority_req,
                fire_time, payload, cancel_id, drop_listener, now, output ready);
endinterface

interface tevq_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] evt_id;
  logic [15:0] lsn_id;
  logic [7:0]  out_type;
  logic [31:0] out_creator;
  logic [31:0] out_target;
  logic [7:0]  out_priority;
  logic [31:0] out_payload;
  logic [4:0]  pending_count;
  logic        last;
  modport source (output valid, status, evt_id, lsn_id, out_type, out_creator,
                  out_target, out_priority, out_payload, pending_count, last, input ready);
  modport sink (input valid, status, evt_id, lsn_id, out_type, out_creator,
                out_target, out_priority, out_payload, pending_count, last, output ready);
endinterface

interface tevq_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> sv/tevq_front.sv
module tevq_front
  import tevq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tevq_in_if.sink     in_ch,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       push;

  always_comb begin
    cmd.evt_type      = in_ch.evt_type;
    cmd.creator       = in_ch.creator;
    cmd.target        = in_ch.target;
    cmd.priority_req  = in_ch.priority_req;
    cmd.fire_time     = in_ch.fire_time;
    cmd.payload       = in_ch.payload;
    cmd.cancel_id     = in_ch.cancel_id;
    cmd.drop_listener = in_ch.drop_listener;
    cmd.now           = in_ch.now;
    case (in_ch.operation)
      OP_POST:   cmd.kind = KIND_POST;
      OP_CANCEL: cmd.kind = KIND_CANCEL;
      OP_REG:    cmd.kind = KIND_REG;
      OP_UNREG:  cmd.kind = KIND_UNREG;
      OP_PROC:   cmd.kind = KIND_PROC;
      default:   cmd.kind = KIND_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_cmd       = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= cmd;
  end

endmodule

>>> sv/tevq_back.sv
module tevq_back
  import tevq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 16,
  parameter int LISTENER_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  tevq_cfg_if.sink    cfg_ch,
  tevq_out_if.source  out_ch
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (LISTENER_SLOTS > 1) ? $clog2(LISTENER_SLOTS) : 1;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t        state_r, state_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt, ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [31:0]   idc_r, idc_nxt;
  logic [15:0]   wcnt_r, wcnt_nxt;
  logic [LW-1:0] wi_r, wi_nxt;
  logic          en_r;
  logic [15:0]   w_id_r   [LISTENER_SLOTS];
  logic [7:0]    w_type_r [LISTENER_SLOTS];
  logic [LISTENER_SLOTS-1:0] w_act_r;

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_q_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;

  logic          out_v_r, can_emit, emit;
  status_t       o_status;
  logic [31:0]   o_id;
  logic [15:0]   o_lid;
  logic          o_use_ent, o_last;

  logic          free_found, drop_found;
  logic [LW-1:0] free_idx, drop_idx;
  logic          reg_we, unreg_we;

  // First free listener slot and first active slot holding the id to drop.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    drop_found = 1'b0;
    drop_idx   = '0;
    for (int i = LISTENER_SLOTS - 1; i >= 0; i--) begin
      if (!w_act_r[i]) begin
        free_found = 1'b1;
        free_idx   = LW'(i);
      end
      if (w_act_r[i] && w_id_r[i] == cur_r.drop_listener) begin
        drop_found = 1'b1;
        drop_idx   = LW'(i);
      end
    end
  end

  assign can_emit     = !out_v_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    idc_nxt   = idc_r;
    wcnt_nxt  = wcnt_r;
    wi_nxt    = wi_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    mem_we    = 1'b0;
    mem_wa    = head_r;
    mem_wd    = rd_q_r;
    emit      = 1'b0;
    o_status  = ST_OK;
    o_id      = '0;
    o_lid     = '0;
    o_use_ent = 1'b0;
    o_last    = 1'b1;
    reg_we    = 1'b0;
    unreg_we  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_cmd;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (cur_r.kind)
          KIND_POST: begin
            if (can_emit) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (cnt_r == CW'(QUEUE_DEPTH)) begin
                o_status = ST_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_wa           = tail_r;
                mem_wd.id        = idc_r;
                mem_wd.etype     = cur_r.evt_type;
                mem_wd.creator   = cur_r.creator;
                mem_wd.target    = cur_r.target;
                mem_wd.prio      = cur_r.priority_req;
                mem_wd.fire_time = cur_r.fire_time;
                mem_wd.payload   = cur_r.payload;
                mem_wd.done      = 1'b0;
                idc_nxt          = idc_r + 32'd1;
                tail_nxt         = ring_next(tail_r);
                cnt_nxt          = cnt_r + 1'b1;
                o_id             = idc_r;
              end
            end
          end
          KIND_CANCEL: begin
            if (cur_r.cancel_id == 32'd0 || cnt_r == '0) begin
              if (can_emit) begin
                emit      = 1'b1;
                o_status  = (cur_r.cancel_id == 32'd0) ? ST_BADID : ST_NOTFOUND;
                state_nxt = S_IDLE;
              end
            end else begin
              ptr_nxt   = head_r;
              idx_nxt   = '0;
              state_nxt = S_CRD;
            end
          end
          KIND_REG: begin
            if (can_emit) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (free_found) begin
                reg_we   = 1'b1;
                o_lid    = wcnt_r;
                wcnt_nxt = wcnt_r + 16'd1;
              end else begin
                o_status = ST_NOSLOT;
              end
            end
          end
          KIND_UNREG: begin
            if (can_emit) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              unreg_we  = drop_found;
              o_status  = drop_found ? ST_OK : ST_NOTFOUND;
            end
          end
          KIND_PROC: begin
            if (en_r && cnt_r != '0) begin
              state_nxt = S_PRD;
            end else if (can_emit) begin
              emit      = 1'b1;
              o_status  = ST_IDLE;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (can_emit) begin
              emit      = 1'b1;
              o_status  = ST_IDLE;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end

      S_CRD: begin
        rd_en     = 1'b1;
        rd_addr   = ptr_r;
        state_nxt = S_CCHK;
      end

      S_CCHK: begin
        if (rd_q_r.id == cur_r.cancel_id && !rd_q_r.done) begin
          if (can_emit) begin
            mem_we      = 1'b1;
            mem_wa      = ptr_r;
            mem_wd.done = 1'b1;
            emit        = 1'b1;
            o_id        = cur_r.cancel_id;
            state_nxt   = S_IDLE;
          end
        end else if (idx_r + 1'b1 == cnt_r) begin
          if (can_emit) begin
            emit      = 1'b1;
            o_status  = ST_NOTFOUND;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ptr_nxt   = ring_next(ptr_r);
          state_nxt = S_CRD;
        end
      end

      S_PRD: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_PCHK;
      end

      S_PCHK: begin
        if (rd_q_r.done) begin
          if (can_emit) begin
            head_nxt  = ring_next(head_r);
            cnt_nxt   = cnt_r - 1'b1;
            emit      = 1'b1;
            o_status  = ST_DROPPED;
            o_id      = rd_q_r.id;
            o_use_ent = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (rd_q_r.fire_time != 32'd0 && rd_q_r.fire_time > cur_r.now) begin
          if (can_emit) begin
            // The entry moves from the head to the tail; in a full ring both are one slot.
            mem_we    = (tail_r != head_r);
            mem_wa    = tail_r;
            head_nxt  = ring_next(head_r);
            tail_nxt  = ring_next(tail_r);
            emit      = 1'b1;
            o_status  = ST_DEFERRED;
            o_id      = rd_q_r.id;
            o_use_ent = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          mem_we      = 1'b1;
          mem_wa      = head_r;
          mem_wd.done = 1'b1;
          head_nxt    = ring_next(head_r);
          cnt_nxt     = cnt_r - 1'b1;
          wi_nxt      = '0;
          state_nxt   = S_FIRE;
        end
      end

      S_FIRE: begin
        if (w_act_r[wi_r] && w_type_r[wi_r] == rd_q_r.etype) begin
          if (can_emit) begin
            emit      = 1'b1;
            o_status  = ST_FIRE;
            o_id      = rd_q_r.id;
            o_lid     = w_id_r[wi_r];
            o_use_ent = 1'b1;
            o_last    = 1'b0;
            wi_nxt    = wi_r + 1'b1;
            if (wi_r == LW'(LISTENER_SLOTS - 1)) state_nxt = S_DONE;
          end
        end else begin
          wi_nxt = wi_r + 1'b1;
          if (wi_r == LW'(LISTENER_SLOTS - 1)) state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (can_emit) begin
          emit      = 1'b1;
          o_status  = ST_DONE;
          o_id      = rd_q_r.id;
          o_use_ent = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      idc_r   <= 32'd1;
      wcnt_r  <= 16'd1;
      en_r    <= 1'b1;
      w_act_r <= '0;
      out_v_r <= 1'b0;
      for (int i = 0; i < LISTENER_SLOTS; i++) begin
        w_id_r[i]   <= '0;
        w_type_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      idc_r   <= idc_nxt;
      wcnt_r  <= wcnt_nxt;
      if (cfg_ch.valid) en_r <= cfg_ch.data;
      if (reg_we) begin
        w_act_r[free_idx]  <= 1'b1;
        w_id_r[free_idx]   <= wcnt_r;
        w_type_r[free_idx] <= cur_r.evt_type;
      end
      if (unreg_we) w_act_r[drop_idx] <= 1'b0;
      if (emit) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ptr_r <= ptr_nxt;
    idx_r <= idx_nxt;
    wi_r  <= wi_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.status        <= o_status;
      out_ch.evt_id        <= o_id;
      out_ch.lsn_id        <= o_lid;
      out_ch.out_type      <= o_use_ent ? rd_q_r.etype : 8'd0;
      out_ch.out_creator   <= o_use_ent ? rd_q_r.creator : 32'd0;
      out_ch.out_target    <= o_use_ent ? rd_q_r.target : 32'd0;
      out_ch.out_priority  <= o_use_ent ? rd_q_r.prio : 8'd0;
      out_ch.out_payload   <= o_use_ent ? rd_q_r.payload : 32'd0;
      out_ch.pending_count <= 5'(cnt_nxt);
      out_ch.last          <= o_last;
    end
  end

  assign out_ch.valid = out_v_r;

endmodule

>>> sv/timed_event_queue_dispatcher.sv
// Timed event queue dispatcher.
// Items arrive on in_ch (valid/ready) and go through a two-entry command queue,
// so the sender can run ahead while the execution engine works. Results leave on
// out_ch from an output register; every item gives one result, except a process
// request that fires listeners, which gives one fire result per matching listener
// and then a done result, the last one flagged with last.
// cfg_ch writes processing_enable at any handshake; it is always ready.
// Post, register, unregister, no-op and idle items give their result from the
// decode state; cancel walks the queue entries, each step one read of the event
// memory followed by a compare; a process reads and checks the head entry, where a
// drop or defer gives its result, and one that fires then visits every listener slot
// before its done result. Items are executed one at a time; the next one is taken
// from the command queue only after the last result of the current one.
// When the receiver holds out_ch.ready low the engine stops at its next result
// and the command queue fills, after which in_ch.ready drops.
// Reset (synchronous, rst_n low) empties the queue, frees all listeners, sets both
// id counters to one and enables processing; the event memory is not cleared.
module timed_event_queue_dispatcher
  import tevq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 16,
  parameter int LISTENER_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  tevq_in_if.sink    in_ch,
  tevq_cfg_if.sink   cfg_ch,
  tevq_out_if.source out_ch
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  tevq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  tevq_back #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .LISTENER_SLOTS (LISTENER_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

>>> dv/tb_timed_event_queue_dispatcher.sv
`timescale 1ns / 1ps
module tb_timed_event_queue_dispatcher;
  import tevq_pkg::*;

  localparam int DEPTH = 16;
  localparam int SLOTS = 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  etype;
    logic [31:0] creator;
    logic [31:0] target;
    logic [7:0]  prio;
    logic [31:0] fire;
    logic [31:0] payload;
    logic [31:0] cancel_id;
    logic [15:0] drop_id;
    logic [31:0] now;
  } request_t;

  typedef struct {
    logic [3:0]  status;
    logic [31:0] evt_id;
    logic [15:0] lsn_id;
    logic [7:0]  etype;
    logic [31:0] creator;
    logic [31:0] target;
    logic [7:0]  prio;
    logic [31:0] payload;
    logic [4:0]  pending;
    logic        last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tevq_in_if  in_ch ();
  tevq_out_if out_ch ();
  tevq_cfg_if cfg_ch ();

  timed_event_queue_dispatcher dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the queue and the listener table.
  logic [31:0] q_id [DEPTH];
  logic [7:0]  q_type [DEPTH];
  logic [31:0] q_creator [DEPTH];
  logic [31:0] q_target [DEPTH];
  logic [7:0]  q_prio [DEPTH];
  logic [31:0] q_fire [DEPTH];
  logic [31:0] q_payload [DEPTH];
  logic        q_done [DEPTH];
  int          q_head, q_tail, q_count;
  logic [31:0] evt_id_ctr;
  logic [15:0] l_id [SLOTS];
  logic [7:0]  l_type [SLOTS];
  logic        l_active [SLOTS];
  logic [15:0] lsn_id_ctr;
  logic        enable_shadow;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  int       sender_idle_pct = 0;
  int       receiver_idle_pct = 0;
  int       hold_cycles = 0;
  logic     in_taken = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic answer_t make_answer(input status_t st, input logic [31:0] id,
                                          input logic [15:0] lid, input int slot,
                                          input logic lst);
    answer_t a;
    a.status = st;
    a.evt_id = id;
    a.lsn_id = lid;
    a.pending = q_count[4:0];
    a.last = lst;
    if (slot >= 0) begin
      a.etype = q_type[slot];
      a.creator = q_creator[slot];
      a.target = q_target[slot];
      a.prio = q_prio[slot];
      a.payload = q_payload[slot];
    end else begin
      a.etype = '0; a.creator = '0; a.target = '0; a.prio = '0; a.payload = '0;
    end
    return a;
  endfunction

  function automatic int ring_step(input int p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  task automatic predict_dispatch(input request_t r);
    int p, h, t;
    bit hit;
    hit = 0;
    case (r.op)
      OP_POST: begin
        if (q_count >= DEPTH) begin
          expected_answers.push_back(make_answer(ST_FULL, 0, 0, -1, 1));
        end else begin
          t = q_tail;
          q_id[t] = evt_id_ctr; q_type[t] = r.etype; q_creator[t] = r.creator;
          q_target[t] = r.target; q_prio[t] = r.prio; q_fire[t] = r.fire;
          q_payload[t] = r.payload; q_done[t] = 1'b0;
          q_tail = ring_step(t);
          q_count++;
          expected_answers.push_back(make_answer(ST_OK, evt_id_ctr, 0, -1, 1));
          evt_id_ctr++;
        end
      end
      OP_CANCEL: begin
        if (r.cancel_id == 0) begin
          expected_answers.push_back(make_answer(ST_BADID, 0, 0, -1, 1));
        end else begin
          p = q_head;
          for (int i = 0; i < q_count && !hit; i++) begin
            if (q_id[p] == r.cancel_id && !q_done[p]) begin
              q_done[p] = 1'b1;
              hit = 1;
            end
            p = ring_step(p);
          end
          if (hit) expected_answers.push_back(make_answer(ST_OK, r.cancel_id, 0, -1, 1));
          else expected_answers.push_back(make_answer(ST_NOTFOUND, 0, 0, -1, 1));
        end
      end
      OP_REG: begin
        for (int i = 0; i < SLOTS && !hit; i++) begin
          if (!l_active[i]) begin
            l_id[i] = lsn_id_ctr; l_type[i] = r.etype; l_active[i] = 1'b1;
            expected_answers.push_back(make_answer(ST_OK, 0, lsn_id_ctr, -1, 1));
            lsn_id_ctr++;
            hit = 1;
          end
        end
        if (!hit) expected_answers.push_back(make_answer(ST_NOSLOT, 0, 0, -1, 1));
      end
      OP_UNREG: begin
        for (int i = 0; i < SLOTS && !hit; i++) begin
          if (l_active[i] && l_id[i] == r.drop_id) begin
            l_active[i] = 1'b0;
            hit = 1;
          end
        end
        if (hit) expected_answers.push_back(make_answer(ST_OK, 0, 0, -1, 1));
        else expected_answers.push_back(make_answer(ST_NOTFOUND, 0, 0, -1, 1));
      end
      OP_PROC: begin
        if (!enable_shadow || q_count == 0) begin
          expected_answers.push_back(make_answer(ST_IDLE, 0, 0, -1, 1));
        end else begin
          h = q_head;
          if (q_done[h]) begin
            q_head = ring_step(h);
            q_count--;
            expected_answers.push_back(make_answer(ST_DROPPED, q_id[h], 0, h, 1));
          end else if (q_fire[h] != 0 && q_fire[h] > r.now) begin
            t = q_tail;
            if (t != h) begin
              q_id[t] = q_id[h]; q_type[t] = q_type[h]; q_creator[t] = q_creator[h];
              q_target[t] = q_target[h]; q_prio[t] = q_prio[h]; q_fire[t] = q_fire[h];
              q_payload[t] = q_payload[h]; q_done[t] = q_done[h];
            end
            q_head = ring_step(h);
            q_tail = ring_step(t);
            expected_answers.push_back(make_answer(ST_DEFERRED, q_id[t], 0, t, 1));
          end else begin
            q_done[h] = 1'b1;
            q_head = ring_step(h);
            q_count--;
            for (int i = 0; i < SLOTS; i++)
              if (l_active[i] && l_type[i] == q_type[h])
                expected_answers.push_back(make_answer(ST_FIRE, q_id[h], l_id[i], h, 0));
            expected_answers.push_back(make_answer(ST_DONE, q_id[h], 0, h, 1));
          end
        end
      end
      default: expected_answers.push_back(make_answer(ST_IDLE, 0, 0, -1, 1));
    endcase
  endtask

  // Remembers whether the offered item was taken at the last rising edge.
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
  end

  // Driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the offered item.
    end else if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
      request_t r;
      r = pending_requests.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.operation <= r.op; in_ch.evt_type <= r.etype; in_ch.creator <= r.creator;
      in_ch.target <= r.target; in_ch.priority_req <= r.prio; in_ch.fire_time <= r.fire;
      in_ch.payload <= r.payload; in_ch.cancel_id <= r.cancel_id;
      in_ch.drop_listener <= r.drop_id; in_ch.now <= r.now;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Monitor: prediction at input acceptance, checking at output acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        request_t r;
        r.op = in_ch.operation; r.etype = in_ch.evt_type; r.creator = in_ch.creator;
        r.target = in_ch.target; r.prio = in_ch.priority_req; r.fire = in_ch.fire_time;
        r.payload = in_ch.payload; r.cancel_id = in_ch.cancel_id;
        r.drop_id = in_ch.drop_listener; r.now = in_ch.now;
        predict_dispatch(r);
      end
      if (cfg_ch.valid && cfg_ch.ready) enable_shadow = cfg_ch.data;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          report($sformatf("unexpected result status %0d", out_ch.status));
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (out_ch.status !== e.status || out_ch.evt_id !== e.evt_id ||
              out_ch.lsn_id !== e.lsn_id || out_ch.out_type !== e.etype ||
              out_ch.out_creator !== e.creator || out_ch.out_target !== e.target ||
              out_ch.out_priority !== e.prio || out_ch.out_payload !== e.payload ||
              out_ch.pending_count !== e.pending || out_ch.last !== e.last)
            report($sformatf({"got st%0d id%0h l%0h t%0h c%0h g%0h p%0h d%0h n%0d z%0b",
                              " want st%0d id%0h l%0h t%0h c%0h g%0h p%0h d%0h n%0d z%0b"},
                             out_ch.status, out_ch.evt_id, out_ch.lsn_id,
                             out_ch.out_type, out_ch.out_creator, out_ch.out_target,
                             out_ch.out_priority, out_ch.out_payload,
                             out_ch.pending_count, out_ch.last, e.status, e.evt_id,
                             e.lsn_id, e.etype, e.creator, e.target, e.prio,
                             e.payload, e.pending, e.last));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic request_t blank_request(input logic [2:0] op);
    request_t r;
    r.op = op;
    r.etype = 8'($urandom); r.creator = $urandom; r.target = $urandom;
    r.prio = 8'($urandom);
    r.fire = 32'd0; r.payload = $urandom; r.cancel_id = $urandom;
    r.drop_id = 16'($urandom);
    r.now = $urandom;
    return r;
  endfunction

  task automatic push_post(input logic [7:0] t, input logic [31:0] f);
    request_t r;
    r = blank_request(OP_POST);
    r.etype = t; r.fire = f;
    pending_requests.push_back(r);
  endtask

  task automatic push_op(input logic [2:0] op, input logic [7:0] t, input logic [31:0] cid,
                         input logic [15:0] did, input logic [31:0] now_val);
    request_t r;
    r = blank_request(op);
    r.etype = t; r.cancel_id = cid; r.drop_id = did; r.now = now_val;
    pending_requests.push_back(r);
  endtask

  // Random mix over a small type set so that listeners match often.
  task automatic push_random(input int n);
    int k;
    request_t r;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      r = blank_request(OP_POST);
      r.etype = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      if (k < 35) begin
        r.op = OP_POST;
        case ($urandom_range(3))
          0: r.fire = 0;
          1: r.fire = $urandom_range(2000);
          2: r.fire = $urandom;
          default: r.fire = 32'hFFFF_FFFF;
        endcase
      end else if (k < 50) begin
        r.op = OP_CANCEL;
        r.cancel_id = ($urandom_range(4) == 0) ? $urandom
                      : 32'(evt_id_ctr + $urandom_range(40)) - 32'd30;
      end else if (k < 60) begin
        r.op = OP_REG;
      end else if (k < 68) begin
        r.op = OP_UNREG;
        r.drop_id = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(40));
      end else if (k < 97) begin
        r.op = OP_PROC;
        r.now = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000);
      end else begin
        r.op = 3'($urandom_range(7, 5));
      end
      pending_requests.push_back(r);
    end
  endtask

  task automatic drain_and_settle();
    while (pending_requests.size() > 0 || in_ch.valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (3 + 2 * DEPTH + SLOTS + 10) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.operation = '0; in_ch.evt_type = '0; in_ch.creator = '0;
    in_ch.target = '0; in_ch.priority_req = '0; in_ch.fire_time = '0; in_ch.payload = '0;
    in_ch.cancel_id = '0; in_ch.drop_listener = '0; in_ch.now = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.data = 1'b0;
    q_head = 0; q_tail = 0; q_count = 0;
    evt_id_ctr = 1; lsn_id_ctr = 1; enable_shadow = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      l_id[i] = '0; l_type[i] = '0; l_active[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty queue, bad ids, listeners, all outcomes of a process.
    push_op(OP_PROC, 0, 0, 0, 0);
    push_op(OP_CANCEL, 0, 0, 0, 0);
    push_op(OP_CANCEL, 0, 32'hFFFF_FFFF, 0, 0);
    push_op(OP_UNREG, 0, 0, 16'hFFFF, 0);
    for (int i = 0; i < SLOTS; i++) push_op(OP_REG, (i < 4) ? 8'h00 : 8'hFF, 0, 0, 0);
    push_op(OP_REG, 8'h12, 0, 0, 0);
    push_op(OP_UNREG, 0, 0, 16'd3, 0);
    push_post(8'h00, 32'd0);
    push_post(8'hFF, 32'hFFFF_FFFF);
    push_post(8'h00, 32'd100);
    push_op(OP_CANCEL, 0, 32'd1, 0, 0);
    push_op(OP_CANCEL, 0, 32'd1, 0, 0);
    push_op(OP_PROC, 0, 0, 0, 32'hFFFF_FFFE);
    push_op(OP_PROC, 0, 0, 0, 32'hFFFF_FFFE);
    push_op(OP_PROC, 0, 0, 0, 32'd100);
    push_op(OP_PROC, 0, 0, 0, 32'hFFFF_FFFF);
    push_op(3'd7, 0, 0, 0, 0);
    sender_idle_pct = 7;
    receiver_idle_pct = 69;
    drain_and_settle();

    // Fill the queue and overflow it, deferring inside a full ring.
    for (int i = 0; i < DEPTH + 2; i++) push_post(8'h00, 32'd5000);
    push_op(OP_PROC, 0, 0, 0, 32'd1);
    push_op(OP_PROC, 0, 0, 0, 32'd1);
    push_random(110);
    drain_and_settle();

    write_enable(1'b0);
    enable_shadow = 1'b0;
    push_op(OP_PROC, 0, 0, 0, 32'hFFFF_FFFF);
    push_random(30);
    drain_and_settle();
    write_enable(1'b1);

    sender_idle_pct = 69;
    receiver_idle_pct = 7;
    push_random(110);
    drain_and_settle();

    // Receiver holds off long while the sender keeps offering.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_cycles = 400;
    push_random(65);
    drain_and_settle();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/tevq_pkg.sv
sv/tevq_if.sv
sv/tevq_front.sv
sv/tevq_back.sv
sv/timed_event_queue_dispatcher.sv
dv/tb_timed_event_queue_dispatcher.sv
